>>> hdl/subsequence_membership_test_unit_defines.svh
// Assertion macros for the checker file of the subsequence test unit.
`ifndef SUBSEQUENCE_MEMBERSHIP_TEST_UNIT_DEFINES_SVH
`define SUBSEQUENCE_MEMBERSHIP_TEST_UNIT_DEFINES_SVH

// Same-cycle implication, sampled on clk and disabled while arst_n is low.
`define SMT_ASSERT_SAME(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, sampled on clk and disabled while arst_n is low.
`define SMT_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

>>> hdl/smt_pkg.sv
`default_nettype none

package smt_pkg;

	localparam int SYM_W      = 8;
	localparam int POS_W      = 12;
	localparam int IN_DATA_W  = 16;
	localparam int OUT_DATA_W = 16;

	// Request kinds carried in tuser.
	localparam logic REQ_LOAD  = 1'b0;
	localparam logic REQ_QUERY = 1'b1;

	typedef enum logic [3:0] {
		ST_IDLE   = 4'b0001,
		ST_SCAN   = 4'b0010,
		ST_CMP    = 4'b0100,
		ST_FINISH = 4'b1000
	} smt_state_t;

endpackage

`default_nettype wire

>>> hdl/smt_text_ram.sv
`default_nettype none

module smt_text_ram #(
	parameter int DEPTH = 4096,
	parameter int AW    = 12
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [AW-1:0]            waddr,
	input  wire logic [smt_pkg::SYM_W-1:0] wdata,
	input  wire logic                     re,
	input  wire logic [AW-1:0]            raddr,
	output logic      [smt_pkg::SYM_W-1:0] rdata
);
	import smt_pkg::*;

	logic [SYM_W-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

`default_nettype wire

>>> hdl/subsequence_membership_test_unit.sv
`default_nettype none
// A load transaction leaves the unit idle, so it is ready again in the next cycle.
// Each probe of a query byte reads the single RAM read port in the scan state and
// compares one byte in the compare state; a match or the end of the text moves the
// search to the finish state. A byte of an already failed query goes straight to finish.
// A last byte also waits in finish while the output register holds an untaken result;
// it is then registered. Reset clears all control state; text RAM is undefined until loaded.

module subsequence_membership_test_unit #(
	parameter int TEXT_DEPTH = 4096
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	// Input stream. s_tdata, from bit 0 up: symbol[7:0], first[8], zero fill.
	input  wire logic                          s_tvalid,
	output logic                               s_tready,
	input  wire logic [smt_pkg::IN_DATA_W-1:0] s_tdata,
	// s_tuser: req_type (0 = append text byte, 1 = query byte).
	input  wire logic                          s_tuser,
	// s_tlast: last byte of a query.
	input  wire logic                          s_tlast,
	// Result stream. m_tdata, from bit 0 up: is_subsequence[0],
	// match_position[12:1], text_overflow[13], zero fill.
	output logic                               m_tvalid,
	input  wire logic                          m_tready,
	output logic [smt_pkg::OUT_DATA_W-1:0]     m_tdata
);
	import smt_pkg::*;

	// LW holds a length from 0 to TEXT_DEPTH; AW addresses one entry.
	localparam int LW = $clog2(TEXT_DEPTH + 1);
	localparam int AW = (TEXT_DEPTH > 1) ? $clog2(TEXT_DEPTH) : 1;
	localparam int EW = (LW > POS_W) ? LW : POS_W;

	smt_state_t st_q;

	logic [LW-1:0]    len_q;     // number of stored text bytes
	logic [LW-1:0]    start_q;   // next text position to probe
	logic             failed_q;  // current query has already failed
	logic             ovf_q;     // text bytes were dropped since the last clear
	logic [SYM_W-1:0] sym_q;     // query byte under search
	logic             last_q;    // query byte under search ends its query

	logic             out_valid_q;
	logic             out_hit_q;
	logic [POS_W-1:0] out_pos_q;
	logic             out_ovf_q;

	logic [SYM_W-1:0] in_sym;
	logic             in_first;
	logic             accept;
	logic             load_acc;
	logic             query_acc;
	logic             room;

	logic             ram_we;
	logic [AW-1:0]    ram_waddr;
	logic             ram_re;
	logic [SYM_W-1:0] ram_rdata;

	logic             scan_end;
	logic             out_load;
	logic             hit;
	logic [EW-1:0]    pos_ext;

	assign in_sym    = s_tdata[SYM_W-1:0];
	assign in_first  = s_tdata[SYM_W];
	assign s_tready  = (st_q == ST_IDLE);
	assign accept    = s_tvalid && s_tready;
	assign load_acc  = accept && (s_tuser == REQ_LOAD);
	assign query_acc = accept && (s_tuser == REQ_QUERY);
	assign room      = (len_q < LW'(TEXT_DEPTH));

	// A clearing load always writes position zero; otherwise the byte is kept only
	// while there is room.
	assign ram_we    = load_acc && (in_first || room);
	assign ram_waddr = in_first ? '0 : len_q[AW-1:0];

	// Positions at or past the stored length end the search with a failure.
	assign scan_end  = (start_q >= len_q);
	assign ram_re    = (st_q == ST_SCAN) && !scan_end;

	smt_text_ram #(
		.DEPTH (TEXT_DEPTH),
		.AW    (AW)
	) u_text_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (in_sym),
		.re    (ram_re),
		.raddr (start_q[AW-1:0]),
		.rdata (ram_rdata)
	);

	// The result slot is free when empty or when its transaction completes now.
	assign out_load = (st_q == ST_FINISH) && last_q && (!out_valid_q || m_tready);
	assign hit      = !failed_q && (start_q != '0);
	assign pos_ext  = EW'(start_q) - EW'(1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q     <= ST_IDLE;
			len_q    <= '0;
			start_q  <= '0;
			failed_q <= 1'b0;
			ovf_q    <= 1'b0;
		end else begin
			case (st_q)
				ST_IDLE: begin
					if (load_acc) begin
						if (in_first) begin
							len_q <= LW'(1);
							ovf_q <= 1'b0;
						end else if (room) begin
							len_q <= len_q + LW'(1);
						end else begin
							ovf_q <= 1'b1;
						end
					end else if (query_acc) begin
						if (in_first) begin
							start_q  <= '0;
							failed_q <= 1'b0;
						end
						// A failed query skips the search for its later bytes.
						if (!in_first && failed_q) begin
							st_q <= ST_FINISH;
						end else begin
							st_q <= ST_SCAN;
						end
					end
				end
				ST_SCAN: begin
					if (scan_end) begin
						failed_q <= 1'b1;
						st_q     <= ST_FINISH;
					end else begin
						st_q <= ST_CMP;
					end
				end
				ST_CMP: begin
					// The pointer moves past the probed position either way; on a match
					// it then holds one past the matched byte.
					start_q <= start_q + LW'(1);
					if (ram_rdata == sym_q) begin
						st_q <= ST_FINISH;
					end else begin
						st_q <= ST_SCAN;
					end
				end
				ST_FINISH: begin
					if (!last_q) begin
						st_q <= ST_IDLE;
					end else if (out_load) begin
						start_q  <= '0;
						failed_q <= 1'b0;
						st_q     <= ST_IDLE;
					end
				end
				default: begin
					st_q <= ST_IDLE;
				end
			endcase
		end
	end

	// Query byte payload, captured when the transaction is taken.
	always_ff @(posedge clk) begin
		if (query_acc) begin
			sym_q  <= in_sym;
			last_q <= s_tlast;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			out_hit_q <= hit;
			out_pos_q <= hit ? pos_ext[POS_W-1:0] : '0;
			out_ovf_q <= ovf_q;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {(OUT_DATA_W - POS_W - 2)'(0), out_ovf_q, out_pos_q, out_hit_q};

endmodule

`default_nettype wire

>>> hdl/smt_checker.sv
`default_nettype none
`include "subsequence_membership_test_unit_defines.svh"

module smt_checker (
	input wire logic                           clk,
	input wire logic                           arst_n,
	input wire logic                           s_tvalid,
	input wire logic                           s_tready,
	input wire logic [smt_pkg::IN_DATA_W-1:0]  s_tdata,
	input wire logic                           s_tuser,
	input wire logic                           s_tlast,
	input wire logic                           m_tvalid,
	input wire logic                           m_tready,
	input wire logic [smt_pkg::OUT_DATA_W-1:0] m_tdata
);
	import smt_pkg::*;

	logic load_acc;
	logic query_acc;

	assign load_acc  = s_tvalid && s_tready && (s_tuser == REQ_LOAD);
	assign query_acc = s_tvalid && s_tready && (s_tuser == REQ_QUERY);

	// A stalled result holds its value.
	`SMT_ASSERT_NEXT(a_out_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata), "result changed while stalled")

	// After a text byte is taken, the unit is ready again in the next cycle and no result is produced.
	`SMT_ASSERT_NEXT(a_load_quick, load_acc, s_tready && !$rose(m_tvalid), "load did not complete in one cycle")

	// Every query byte keeps the unit busy: s_tready is low in the cycle after it is taken.
	`SMT_ASSERT_NEXT(a_query_busy, query_acc, !s_tready, "query byte taken without search")

	// A failed query reports position zero, and the fill bits stay zero.
	`SMT_ASSERT_SAME(a_fail_pos, m_tvalid, (m_tdata[0] || (m_tdata[12:1] == '0)) && (m_tdata[15:14] == '0), "bad result encoding")

endmodule

bind subsequence_membership_test_unit smt_checker u_smt_checker (.*);

`default_nettype wire
